>>> rtl/a2a_pkg.sv
// Shared types and fixed-point constants for the atan2 angle block.
`timescale 1ns / 1ps
`default_nettype none
package a2a_pkg;

    // All constants are Q30 magnitudes rounded to nearest.
    localparam logic [31:0] Q_ONE    = 32'd1073741824;
    localparam logic [31:0] K_TAN12  = 32'd287708255;
    localparam logic [31:0] K_TAN6   = 32'd619925131;
    localparam logic [31:0] K_PI6    = 32'd562209904;
    localparam logic [31:0] K_HALFPI = 32'd1686629713;
    localparam logic [31:0] K_PI     = 32'd3373259426;
    localparam logic [31:0] K_C1     = 32'd1811147884;
    localparam logic [31:0] K_C2     = 32'd470137568;
    localparam logic [31:0] K_C3     = 32'd1811148317;

    // Classification of one input pair, made by the front end.
    typedef struct packed {
        logic x_zero;
        logic y_zero;
        logic comp;
        logic xneg;
        logic yneg;
    } t_flags;

endpackage
`default_nettype wire

>>> rtl/a2a_front.sv
// Front end: magnitudes, sign and octant classification of one input pair.
`timescale 1ns / 1ps
`default_nettype none
module a2a_front #(
    parameter int IN_WIDTH = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire [31:0]          i_y_value,
    input  wire [31:0]          i_x_value,
    output logic                o_valid,
    output logic [IN_WIDTH-1:0] o_lo,
    output logic [IN_WIDTH-1:0] o_hi,
    output a2a_pkg::t_flags     o_flags
);

    logic [IN_WIDTH-1:0] n_yv, n_xv, n_ym, n_xm;
    a2a_pkg::t_flags     n_flags;

    always_comb begin
        n_yv  = i_y_value[IN_WIDTH-1:0];
        n_xv  = i_x_value[IN_WIDTH-1:0];
        // The most negative code maps onto its exact magnitude in the same width.
        n_ym  = n_yv[IN_WIDTH-1] ? (~n_yv + 1'b1) : n_yv;
        n_xm  = n_xv[IN_WIDTH-1] ? (~n_xv + 1'b1) : n_xv;
        n_flags.x_zero = (n_xm == '0);
        n_flags.y_zero = (n_ym == '0);
        n_flags.comp   = (n_ym > n_xm);
        n_flags.xneg   = n_xv[IN_WIDTH-1];
        n_flags.yneg   = n_yv[IN_WIDTH-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
        o_lo    <= n_flags.comp ? n_xm : n_ym;
        o_hi    <= n_flags.comp ? n_ym : n_xm;
        o_flags <= n_flags;
    end

endmodule
`default_nettype wire

>>> rtl/a2a_queue.sv
// Two-entry queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
`default_nettype none
module a2a_queue #(
    parameter int WIDTH = 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire [WIDTH-1:0]  i_data,
    input  wire              i_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr, r_rd;
    logic [1:0]       r_count;
    logic             n_pop;

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_count == 2'd2);
    assign n_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (n_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, n_pop};
        end
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

>>> rtl/a2a_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`timescale 1ns / 1ps
`default_nettype none
module a2a_div #(
    parameter int DW = 32,
    parameter int QW = 31,
    parameter int SW = 1
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    input  wire [DW-1:0]  i_rem,
    input  wire [QW-1:0]  i_low,
    input  wire [DW-1:0]  i_div,
    input  wire [SW-1:0]  i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_low  [QW];
    logic [QW-1:0] r_quo  [QW];
    logic [DW-1:0] r_div  [QW];
    logic [SW-1:0] r_side [QW];
    logic          r_vld  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] p_rem, p_div;
        logic [QW-1:0] p_low, p_quo;
        logic [SW-1:0] p_side;
        logic          p_vld;
        logic [DW:0]   n_trial;
        logic          n_ge;

        if (k == 0) begin : g_first
            assign p_rem  = i_rem;
            assign p_low  = i_low;
            assign p_quo  = '0;
            assign p_div  = i_div;
            assign p_side = i_side;
            assign p_vld  = i_valid;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_low  = r_low[k-1];
            assign p_quo  = r_quo[k-1];
            assign p_div  = r_div[k-1];
            assign p_side = r_side[k-1];
            assign p_vld  = r_vld[k-1];
        end

        assign n_trial = {p_rem, p_low[QW-1]};
        assign n_ge    = (n_trial >= {1'b0, p_div});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= p_vld;
            end
            r_rem[k]  <= n_ge ? DW'(n_trial - {1'b0, p_div}) : n_trial[DW-1:0];
            r_low[k]  <= {p_low[QW-2:0], 1'b0};
            r_quo[k]  <= {p_quo[QW-2:0], n_ge};
            r_div[k]  <= p_div;
            r_side[k] <= p_side;
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule
`default_nettype wire

>>> rtl/a2a_back.sv
// Back end: ratio, range reduction, rational approximation and quadrant fix.
`timescale 1ns / 1ps
`default_nettype none
module a2a_back #(
    parameter int IN_WIDTH        = 32,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    input  wire [IN_WIDTH-1:0]         i_lo,
    input  wire [IN_WIDTH-1:0]         i_hi,
    input  a2a_pkg::t_flags            i_flags,
    output logic                       o_strobe,
    output logic [ANGLE_FRAC_BITS+2:0] o_angle
);

    localparam int FW  = $bits(a2a_pkg::t_flags);
    localparam int SH  = 30 - ANGLE_FRAC_BITS;
    localparam int OW  = ANGLE_FRAC_BITS + 3;
    localparam int S2W = FW + 32;
    localparam int S3W = FW + 2;

    // Ratio t = (lo << 30) / hi, 31 quotient bits.
    logic                  d1_valid;
    logic [30:0]           d1_t;
    a2a_pkg::t_flags       d1_flags;

    a2a_div #(.DW(IN_WIDTH), .QW(31), .SW(FW)) u_div_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_rem   ({1'b0, i_lo[IN_WIDTH-1:1]}),
        .i_low   ({i_lo[0], 30'd0}),
        .i_div   (i_hi),
        .i_side  (i_flags),
        .o_valid (d1_valid),
        .o_quo   (d1_t),
        .o_side  (d1_flags)
    );

    // Stage A: rotation product.
    logic            r_a_vld;
    logic [30:0]     r_a_t;
    logic [59:0]     r_a_prod;
    a2a_pkg::t_flags r_a_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= d1_valid;
        end
        r_a_t     <= d1_t;
        r_a_prod  <= a2a_pkg::K_TAN6[29:0] * d1_t;
        r_a_flags <= d1_flags;
    end

    // Stage B: rotated numerator and denominator.
    logic            r_b_vld, r_b_rot, r_b_uneg;
    logic [30:0]     r_b_num, r_b_dd;
    logic [29:0]     r_b_t;
    a2a_pkg::t_flags r_b_flags;
    logic            n_b_rot, n_b_ge;

    assign n_b_rot = ({1'b0, r_a_t} > a2a_pkg::K_TAN12);
    assign n_b_ge  = ({1'b0, r_a_t} >= a2a_pkg::K_TAN6);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_rot   <= n_b_rot;
        r_b_uneg  <= n_b_rot && !n_b_ge;
        r_b_num   <= n_b_ge ? (r_a_t - a2a_pkg::K_TAN6[30:0])
                            : (a2a_pkg::K_TAN6[30:0] - r_a_t);
        r_b_dd    <= a2a_pkg::Q_ONE[30:0] + {1'b0, r_a_prod[59:30]};
        r_b_t     <= r_a_t[29:0];
        r_b_flags <= r_a_flags;
    end

    // Rotated ratio u = (num << 30) / dd; unrotated items ride along.
    logic           d2_valid;
    logic [29:0]    d2_u;
    logic [S2W-1:0] d2_side;

    a2a_div #(.DW(31), .QW(30), .SW(S2W)) u_div_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_vld),
        .i_rem   (r_b_num),
        .i_low   (30'd0),
        .i_div   (r_b_dd),
        .i_side  ({r_b_flags, r_b_rot, r_b_uneg, r_b_t}),
        .o_valid (d2_valid),
        .o_quo   (d2_u),
        .o_side  (d2_side)
    );

    // Stage C: choose u and square it.
    logic           r_c_vld;
    logic [29:0]    r_c_u;
    logic [59:0]    r_c_sq;
    logic [S3W-1:0] r_c_side;
    logic [29:0]    n_c_u;

    assign n_c_u = d2_side[31] ? d2_u : d2_side[29:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= d2_valid;
        end
        r_c_u    <= n_c_u;
        r_c_sq   <= n_c_u * n_c_u;
        r_c_side <= d2_side[S2W-1:30];
    end

    // Stage D: u^2 times C2, and the denominator.
    logic           r_d_vld;
    logic [29:0]    r_d_u;
    logic [58:0]    r_d_p;
    logic [30:0]    r_d_den;
    logic [S3W-1:0] r_d_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
        r_d_u    <= r_c_u;
        r_d_p    <= r_c_sq[59:30] * a2a_pkg::K_C2[28:0];
        r_d_den  <= a2a_pkg::K_C3[30:0] + {1'b0, r_c_sq[59:30]};
        r_d_side <= r_c_side;
    end

    // Stage E: numerator factor.
    logic           r_e_vld;
    logic [29:0]    r_e_u;
    logic [30:0]    r_e_fac, r_e_den;
    logic [S3W-1:0] r_e_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= r_d_vld;
        end
        r_e_u    <= r_d_u;
        r_e_fac  <= a2a_pkg::K_C1[30:0] + {2'b00, r_d_p[58:30]};
        r_e_den  <= r_d_den;
        r_e_side <= r_d_side;
    end

    // Stage F: u times the factor.
    logic           r_f_vld;
    logic [60:0]    r_f_prod;
    logic [30:0]    r_f_den;
    logic [S3W-1:0] r_f_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_e_vld;
        end
        r_f_prod <= r_e_u * r_e_fac;
        r_f_den  <= r_e_den;
        r_f_side <= r_e_side;
    end

    // Rational quotient r = (u * fac) / den.
    logic           d3_valid;
    logic [29:0]    d3_r;
    logic [S3W-1:0] d3_side;

    a2a_div #(.DW(31), .QW(30), .SW(S3W)) u_div_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f_vld),
        .i_rem   (r_f_prod[60:30]),
        .i_low   (r_f_prod[29:0]),
        .i_div   (r_f_den),
        .i_side  (r_f_side),
        .o_valid (d3_valid),
        .o_quo   (d3_r),
        .o_side  (d3_side)
    );

    // Stage G: add back pi/6, complement and quadrant correction.
    a2a_pkg::t_flags g_flags;
    logic            g_rot, g_uneg, n_g_neg;
    logic [31:0]     n_g_a1, n_g_a2, n_g_m;
    logic            r_g_vld, r_g_neg;
    logic [31:0]     r_g_m;

    always_comb begin
        g_flags = d3_side[S3W-1:2];
        g_rot   = d3_side[1];
        g_uneg  = d3_side[0];
        if (!g_rot) begin
            n_g_a1 = {2'b00, d3_r};
        end else if (g_uneg) begin
            n_g_a1 = ({2'b00, d3_r} > a2a_pkg::K_PI6) ? '0
                                                      : a2a_pkg::K_PI6 - {2'b00, d3_r};
        end else begin
            n_g_a1 = a2a_pkg::K_PI6 + {2'b00, d3_r};
        end
        if (g_flags.comp) begin
            n_g_a2 = (n_g_a1 > a2a_pkg::K_HALFPI) ? '0 : a2a_pkg::K_HALFPI - n_g_a1;
        end else begin
            n_g_a2 = n_g_a1;
        end
        if (g_flags.x_zero) begin
            n_g_m = g_flags.y_zero ? '0 : a2a_pkg::K_HALFPI;
        end else if (g_flags.xneg) begin
            n_g_m = (n_g_a2 > a2a_pkg::K_PI) ? '0 : a2a_pkg::K_PI - n_g_a2;
        end else begin
            n_g_m = n_g_a2;
        end
        n_g_neg = g_flags.yneg && (n_g_m != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else begin
            r_g_vld <= d3_valid;
        end
        r_g_m   <= n_g_m;
        r_g_neg <= n_g_neg;
    end

    // Stage H: round to nearest, ties away from zero, then apply the sign.
    logic [32:0]   n_h_sum;
    logic [OW-1:0] n_h_q;

    assign n_h_sum = {1'b0, r_g_m} + (33'd1 << (SH - 1));
    assign n_h_q   = n_h_sum[32:SH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_g_vld;
        end
        o_angle <= r_g_neg ? (~n_h_q + 1'b1) : n_h_q;
    end

endmodule
`default_nettype wire

>>> rtl/atan2_angle_approximation.sv
// Top level of the fixed-point four-quadrant arctangent block.
// Throughput: one beat per clock; a new pair may be started in every cycle.
// The path is dominated by the three bit-per-stage dividers (31, 30, 30 stages), with
// the front register, the queue and the back-end stages A to H around them.
// The receiver cannot stall, so the queue never fills and busy stays low.
// Reset is synchronous and active low; it clears all valid flags and the queue.
`timescale 1ns / 1ps
`default_nettype none
module atan2_angle_approximation #(
    parameter int IN_WIDTH        = 32,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        start,
    output logic                       busy,
    input  wire [31:0]                 i_y_value,
    input  wire [31:0]                 i_x_value,
    output logic                       o_strobe,
    output logic [ANGLE_FRAC_BITS+2:0] o_angle
);

    localparam int FW = $bits(a2a_pkg::t_flags);
    localparam int QW = 2 * IN_WIDTH + FW;

    // The front end classifies a beat and registers the result: it forms both magnitudes,
    // decides whether the ratio must be taken reciprocally, and flags the
    // axis cases that bypass the arithmetic.
    logic                f_valid;
    logic [IN_WIDTH-1:0] f_lo, f_hi;
    a2a_pkg::t_flags     f_flags;

    a2a_front #(.IN_WIDTH(IN_WIDTH)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start && !busy),
        .i_y_value (i_y_value),
        .i_x_value (i_x_value),
        .o_valid   (f_valid),
        .o_lo      (f_lo),
        .o_hi      (f_hi),
        .o_flags   (f_flags)
    );

    // A short queue decouples the front end from the arithmetic pipeline.
    // The back end takes one beat per cycle, so it drains as fast as it fills.
    logic          q_valid, q_full;
    logic [QW-1:0] q_data;

    a2a_queue #(.WIDTH(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  ({f_lo, f_hi, f_flags}),
        .i_ready (1'b1),
        .o_valid (q_valid),
        .o_data  (q_data),
        .o_full  (q_full)
    );

    assign busy = q_full;

    // The back end forms the ratio, reduces its range, evaluates the rational
    // approximation and places the angle in its quadrant.
    a2a_back #(
        .IN_WIDTH        (IN_WIDTH),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_lo     (q_data[QW-1:IN_WIDTH+FW]),
        .i_hi     (q_data[IN_WIDTH+FW-1:FW]),
        .i_flags  (q_data[FW-1:0]),
        .o_strobe (o_strobe),
        .o_angle  (o_angle)
    );

endmodule
`default_nettype wire
